// File: sv/bma_pkg.sv
// Shared types, sizes and codes for the block map allocator.
package bma_pkg;

	localparam int MAP_ENTRIES = 64;
	localparam int BLOCK_BYTES = 32;

	localparam int IDX_W      = $clog2(MAP_ENTRIES);
	localparam int ENTRY_W    = $clog2(MAP_ENTRIES + 1);
	localparam int SIZE_W     = 16;
	localparam int OFF_W      = 11;
	localparam int PCT_W      = 7;
	localparam int PCT_SCALE  = 100;
	localparam int PROD_W     = $clog2(MAP_ENTRIES * PCT_SCALE + 1);
	localparam int DIVD_W     = (PROD_W > SIZE_W) ? PROD_W : SIZE_W;
	localparam int DSR_MAX    = (BLOCK_BYTES > MAP_ENTRIES) ? BLOCK_BYTES : MAP_ENTRIES;
	localparam int DIVS_W     = $clog2(DSR_MAX + 1);
	localparam int SHAMT_W    = $clog2(DIVD_W);
	localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int MAP_SHIFT   = $clog2(MAP_ENTRIES);
	localparam logic [31:0] POOL_BYTES = 32'(MAP_ENTRIES * BLOCK_BYTES);

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_QUERY = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAIL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_SCAN,
		S_MARK,
		S_READ,
		S_RELEASE,
		S_PCT_GO,
		S_PCT_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               mark;
		logic               drop;
		logic               wipe;
		logic [IDX_W-1:0]   addr;
		logic [ENTRY_W-1:0] wdata;
	} map_req_t;

endpackage

// File: sv/bma_div.sv
// Shared power-of-two divider: shift for the quotient, mask for the remainder.
module bma_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bma_pkg::DIVD_W-1:0]  dividend,
	input  logic [bma_pkg::SHAMT_W-1:0] shamt,
	output logic                        done,
	output logic [bma_pkg::DIVD_W-1:0]  quot,
	output logic [bma_pkg::DIVS_W-1:0]  rem
);
	import bma_pkg::*;

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic              done_q;
	logic [DIVD_W-1:0] low_mask;

	assign low_mask = ~({DIVD_W{1'b1}} << shamt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend >> shamt;
			rem_q <= DIVS_W'(dividend & low_mask);
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(start))
		else $error("divider done without a start");
	a_start_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !start)
		else $error("divider started on consecutive cycles");

endmodule

// File: sv/bma_map.sv
// Allocation map: run-length memory, occupancy bits and used-entry count.
module bma_map (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bma_pkg::map_req_t           req,
	output logic                        occupied,
	output logic [bma_pkg::ENTRY_W-1:0] rdata,
	output logic [bma_pkg::ENTRY_W-1:0] used
);
	import bma_pkg::*;

	logic [ENTRY_W-1:0]     mem [MAP_ENTRIES];
	logic [ENTRY_W-1:0]     rdata_q;
	logic [MAP_ENTRIES-1:0] valid_q;
	logic [ENTRY_W-1:0]     used_q;

	assign occupied = valid_q[req.addr];

	always_ff @(posedge clk) begin
		if (req.mark) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else if (req.wipe) begin
			valid_q <= '0;
			used_q  <= '0;
		end else if (req.mark) begin
			valid_q[req.addr] <= 1'b1;
			if (!valid_q[req.addr]) begin
				used_q <= used_q + 1'b1;
			end
		end else if (req.drop) begin
			valid_q[req.addr] <= 1'b0;
			if (valid_q[req.addr]) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	assign rdata = rdata_q;
	assign used  = used_q;

	a_used_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(used_q))
		else $error("used count out of step with occupancy");
	a_mark_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.mark |-> !valid_q[req.addr])
		else $error("mark on an occupied entry");

endmodule

// File: sv/block_map_allocator_top.sv
// Block map allocator top level: sequencer, beat capture and result register.
//
// One input beat (action, alloc_size, free_offset) on in_valid/in_ready gives
// exactly one result beat (status, block_offset, percent_used) on
// out_valid/out_ready. Items are handled one at a time: in_ready is high only
// while the sequencer is idle.
// Query, clear, zero-size allocate and free beyond the pool go straight to the
// percentage step; an allocate larger than the pool stops after the block count;
// a free reads the run length at its block index and clears those entries; an
// allocate scans the map from the top for a free run and marks each entry of it.
// The map is walked one entry per cycle; one shared shift-and-mask unit gives
// the block count, the block index and the percentage, in the cycle after start.
// Reset clears every occupancy bit at once; the block is ready on the first
// cycle after reset. A finished result sits in the output register; while
// the receiver stalls a completed next item waits in the sequencer until
// the register frees up.
module block_map_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [bma_pkg::SIZE_W-1:0]  alloc_size,
	input  logic [bma_pkg::SIZE_W-1:0]  free_offset,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [bma_pkg::OFF_W-1:0]   block_offset,
	output logic [bma_pkg::PCT_W-1:0]   percent_used
);
	import bma_pkg::*;

	state_t             state_q, state_nx;
	act_t               act_q;
	logic [SIZE_W-1:0]  size_q;
	logic [SIZE_W-1:0]  foff_q;
	status_t            stat_q;
	logic [ENTRY_W-1:0] want_q;
	logic [IDX_W-1:0]   pos_q;
	logic [ENTRY_W-1:0] run_q;
	logic [IDX_W-1:0]   base_q;
	logic [ENTRY_W-1:0] cnt_q;
	logic [ENTRY_W-1:0] len_q;
	logic [PCT_W-1:0]   pct_q;

	logic               out_valid_q;
	status_t            o_status_q;
	logic [OFF_W-1:0]   o_offset_q;
	logic [PCT_W-1:0]   o_pct_q;

	logic               accept;
	logic               out_free;
	logic               size_zero;
	logic               beyond_pool;
	logic [DIVD_W:0]    want_full;
	logic               want_big;
	logic [ENTRY_W-1:0] run_nx;
	logic               hit;
	logic [ENTRY_W:0]   rel_pos;
	logic               rel_go;
	logic [31:0]        off_full;

	logic               div_start;
	logic [DIVD_W-1:0]  div_dividend;
	logic [SHAMT_W-1:0] div_shamt;
	logic               div_done;
	logic [DIVD_W-1:0]  div_quot;
	logic [DIVS_W-1:0]  div_rem;

	map_req_t           map_req;
	logic               occupied;
	logic [ENTRY_W-1:0] map_rdata;
	logic [ENTRY_W-1:0] used;

	bma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.shamt    (div_shamt),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	bma_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (map_req),
		.occupied (occupied),
		.rdata    (map_rdata),
		.used     (used)
	);

	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign size_zero   = alloc_size == '0;
	assign beyond_pool = {16'b0, free_offset} >= POOL_BYTES;
	assign want_full   = {1'b0, div_quot} + (DIVD_W+1)'(div_rem != '0);
	assign want_big    = want_full > (DIVD_W+1)'(MAP_ENTRIES);
	assign run_nx      = occupied ? '0 : run_q + 1'b1;
	assign hit         = run_nx == want_q;
	assign rel_pos     = (ENTRY_W+1)'(base_q) + (ENTRY_W+1)'(cnt_q);
	assign rel_go      = (cnt_q < len_q) && (rel_pos < (ENTRY_W+1)'(MAP_ENTRIES));
	assign off_full    = 32'(base_q) * 32'(BLOCK_BYTES);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (act_t'(action))
						ACT_ALLOC: state_nx = size_zero ? S_PCT_GO : S_DIV_GO;
						ACT_FREE:  state_nx = beyond_pool ? S_PCT_GO : S_DIV_GO;
						default:   state_nx = S_PCT_GO;
					endcase
				end
			end
			S_DIV_GO: state_nx = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_done) begin
					if (act_q == ACT_ALLOC) begin
						state_nx = want_big ? S_PCT_GO : S_SCAN;
					end else begin
						state_nx = S_READ;
					end
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_nx = S_MARK;
				end else if (pos_q == '0) begin
					state_nx = S_PCT_GO;
				end
			end
			S_MARK: begin
				if (cnt_q == want_q - 1'b1) begin
					state_nx = S_PCT_GO;
				end
			end
			S_READ:    state_nx = S_RELEASE;
			S_RELEASE: state_nx = rel_go ? S_RELEASE : S_PCT_GO;
			S_PCT_GO:  state_nx = S_PCT_WAIT;
			S_PCT_WAIT: begin
				if (div_done) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready      = 1'b0;
		div_start     = 1'b0;
		div_dividend  = DIVD_W'(size_q);
		div_shamt     = SHAMT_W'(BLOCK_SHIFT);
		map_req       = '0;
		map_req.addr  = base_q;
		map_req.wdata = want_q;
		case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				map_req.wipe = in_valid && (act_t'(action) == ACT_CLEAR);
			end
			S_DIV_GO: begin
				div_start    = 1'b1;
				div_dividend = (act_q == ACT_ALLOC) ? DIVD_W'(size_q) : DIVD_W'(foff_q);
			end
			S_DIV_WAIT: map_req.addr = div_quot[IDX_W-1:0];
			S_SCAN:     map_req.addr = pos_q;
			S_MARK: begin
				map_req.mark = 1'b1;
				map_req.addr = base_q + cnt_q[IDX_W-1:0];
			end
			S_RELEASE: begin
				map_req.drop = rel_go;
				map_req.addr = rel_pos[IDX_W-1:0];
			end
			S_PCT_GO: begin
				div_start    = 1'b1;
				div_dividend = DIVD_W'(used) * DIVD_W'(PCT_SCALE);
				div_shamt    = SHAMT_W'(MAP_SHIFT);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					act_q  <= act_t'(action);
					size_q <= alloc_size;
					foff_q <= free_offset;
					base_q <= '0;
					stat_q <= ST_OK;
					if (act_t'(action) == ACT_ALLOC && size_zero) begin
						stat_q <= ST_FAIL;
					end else if (act_t'(action) == ACT_FREE && beyond_pool) begin
						stat_q <= ST_RANGE;
					end
				end
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					want_q <= want_full[ENTRY_W-1:0];
					pos_q  <= IDX_W'(MAP_ENTRIES - 1);
					run_q  <= '0;
					base_q <= div_quot[IDX_W-1:0];
					if (act_q == ACT_ALLOC && want_big) begin
						stat_q <= ST_FAIL;
					end
				end
			end
			S_SCAN: begin
				run_q <= run_nx;
				pos_q <= pos_q - 1'b1;
				if (hit) begin
					base_q <= pos_q;
					cnt_q  <= '0;
				end else if (pos_q == '0) begin
					stat_q <= ST_FAIL;
				end
			end
			S_MARK:    cnt_q <= cnt_q + 1'b1;
			S_READ: begin
				len_q <= occupied ? map_rdata : '0;
				cnt_q <= '0;
			end
			S_RELEASE: cnt_q <= cnt_q + 1'b1;
			S_PCT_WAIT: begin
				if (div_done) begin
					pct_q <= div_quot[PCT_W-1:0];
				end
			end
			S_DONE: begin
				if (out_free) begin
					o_status_q <= stat_q;
					o_pct_q    <= pct_q;
					o_offset_q <= (act_q == ACT_ALLOC && stat_q == ST_OK) ?
						off_full[OFF_W-1:0] : '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = o_status_q;
	assign block_offset = o_offset_q;
	assign percent_used = o_pct_q;

	a_offset_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && o_status_q != ST_OK |-> o_offset_q == '0)
		else $error("nonzero offset on a failed result");
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer stayed idle after a beat");

endmodule

// File: tb/sv/block_map_allocator_top_tb.sv
`timescale 1ns / 100ps
// Testbench for block_map_allocator_top: directed table, then random traffic against a predictor.
module block_map_allocator_top_tb;
	import bma_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 1_200_000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		status_t          status;
		logic [OFF_W-1:0] offset;
		logic [PCT_W-1:0] pct;
	} outcome_t;

	typedef struct {
		act_t              act;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] off;
		bit                typed;
		outcome_t          res;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          action;
	logic [SIZE_W-1:0]   alloc_size;
	logic [SIZE_W-1:0]   free_offset;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic [OFF_W-1:0]    block_offset;
	logic [PCT_W-1:0]    percent_used;

	logic [ENTRY_W-1:0]  block_len [MAP_ENTRIES];
	outcome_t            pending_results [$];
	outcome_t            last_outcome;
	dir_row_t            dir_rows [$];
	logic [OFF_W-1:0]    live_grants [$];
	int                  tx_idle_pct;
	int                  rx_idle_pct;
	int                  errors = 0;
	int                  cycles = 0;

	block_map_allocator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.alloc_size   (alloc_size),
		.free_offset  (free_offset),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.block_offset (block_offset),
		.percent_used (percent_used)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic outcome_t apply_request(act_t act, logic [SIZE_W-1:0] size,
			logic [SIZE_W-1:0] off);
		outcome_t res;
		int       want;
		int       run;
		int       idx;
		int       len;
		int       used;
		bit       found;
		res.status = ST_OK;
		res.offset = '0;
		found = 1'b0;
		case (act)
			ACT_ALLOC: begin
				want = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
				if (size != 0 && want <= MAP_ENTRIES) begin
					run = 0;
					for (int pos = MAP_ENTRIES - 1; pos >= 0 && !found; pos--) begin
						run = (block_len[pos] == 0) ? run + 1 : 0;
						if (run == want) begin
							found = 1'b1;
							for (int i = 0; i < want; i++)
								block_len[pos + i] = ENTRY_W'(want);
							res.offset = OFF_W'(pos * BLOCK_BYTES);
						end
					end
				end
				if (!found)
					res.status = ST_FAIL;
			end
			ACT_FREE: begin
				if (32'(off) >= POOL_BYTES) begin
					res.status = ST_RANGE;
				end else begin
					idx = int'(off) / BLOCK_BYTES;
					len = int'(block_len[idx]);
					for (int i = 0; i < len && idx + i < MAP_ENTRIES; i++)
						block_len[idx + i] = '0;
				end
			end
			ACT_CLEAR: begin
				foreach (block_len[i])
					block_len[i] = '0;
			end
			default: ;
		endcase
		used = 0;
		foreach (block_len[i])
			if (block_len[i] != 0)
				used++;
		res.pct = PCT_W'(used * PCT_SCALE / MAP_ENTRIES);
		return res;
	endfunction

	function automatic void add_row(act_t act, logic [SIZE_W-1:0] size,
			logic [SIZE_W-1:0] off, bit typed, status_t st = ST_OK,
			logic [OFF_W-1:0] offs = '0, logic [PCT_W-1:0] pct = '0);
		dir_row_t row;
		row.act = act;
		row.size = size;
		row.off = off;
		row.typed = typed;
		row.res.status = st;
		row.res.offset = offs;
		row.res.pct = pct;
		dir_rows.push_back(row);
	endfunction

	task automatic issue(act_t act, logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] off,
			bit typed = 1'b0, outcome_t typed_res = '{ST_OK, '0, '0});
		@(negedge clk);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct);
		end
		action <= act;
		alloc_size <= size;
		free_offset <= off;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		last_outcome = apply_request(act, size, off);
		pending_results.push_back(typed ? typed_res : last_outcome);
	endtask

	task automatic drain_hold;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_item;
		int                r;
		int                k;
		act_t              act;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] off;
		r = $urandom_range(0, 99);
		size = SIZE_W'($urandom);
		off = SIZE_W'($urandom);
		if (r < 45) begin
			act = ACT_ALLOC;
			k = $urandom_range(0, 9);
			if (k < 7)
				size = SIZE_W'($urandom_range(1, 10 * BLOCK_BYTES));
			else if (k < 9)
				size = SIZE_W'($urandom_range(10 * BLOCK_BYTES + 1, MAP_ENTRIES * BLOCK_BYTES));
		end else if (r < 80) begin
			act = ACT_FREE;
			if (live_grants.size() != 0) begin
				k = $urandom_range(0, live_grants.size() - 1);
				off = SIZE_W'(live_grants[k]);
				if ($urandom_range(0, 7) == 0)
					off = off + SIZE_W'($urandom_range(0, BLOCK_BYTES - 1));
				live_grants.delete(k);
			end else begin
				off = SIZE_W'($urandom_range(0, MAP_ENTRIES * BLOCK_BYTES - 1));
			end
		end else if (r < 85) begin
			act = ACT_CLEAR;
		end else if (r < 90) begin
			act = ACT_QUERY;
		end else begin
			act = act_t'($urandom_range(0, 3));
		end
		issue(act, size, off);
		if (act == ACT_CLEAR)
			live_grants.delete();
		else if (act == ACT_ALLOC && last_outcome.status == ST_OK)
			live_grants.push_back(last_outcome.offset);
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	always @(posedge clk) begin
		outcome_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: status %0d offset %0d percent %0d",
					status, block_offset, percent_used);
				errors++;
			end else begin
				exp = pending_results.pop_front();
				if (status !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, status);
					errors++;
				end
				if (block_offset !== exp.offset) begin
					$error("block_offset: expected %0d, got %0d", exp.offset, block_offset);
					errors++;
				end
				if (percent_used !== exp.pct) begin
					$error("percent_used: expected %0d, got %0d", exp.pct, percent_used);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		outcome_t typed_res;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_QUERY;
		alloc_size = '0;
		free_offset = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		foreach (block_len[i])
			block_len[i] = '0;

		add_row(ACT_QUERY, 16'h0000, 16'h0000, 1'b1, ST_OK, 0, 0);
		add_row(ACT_ALLOC, 16'd0, 16'hFFFF, 1'b1, ST_FAIL, 0, 0);
		add_row(ACT_ALLOC, 16'hFFFF, 16'h0000, 1'b1, ST_FAIL, 0, 0);
		add_row(ACT_ALLOC, 16'd2049, 16'h0000, 1'b1, ST_FAIL, 0, 0);
		add_row(ACT_ALLOC, 16'd2048, 16'h0000, 1'b1, ST_OK, 0, 100);
		add_row(ACT_ALLOC, 16'd1, 16'h0000, 1'b1, ST_FAIL, 0, 100);
		add_row(ACT_FREE, 16'h0000, 16'd2048, 1'b1, ST_RANGE, 0, 100);
		add_row(ACT_FREE, 16'hFFFF, 16'hFFFF, 1'b1, ST_RANGE, 0, 100);
		add_row(ACT_FREE, 16'h0000, 16'd0, 1'b1, ST_OK, 0, 0);
		add_row(ACT_ALLOC, 16'd1, 16'h0000, 1'b1, ST_OK, 2016, 1);
		add_row(ACT_ALLOC, 16'd32, 16'h5555, 1'b0);
		add_row(ACT_ALLOC, 16'd33, 16'hAAAA, 1'b0);
		add_row(ACT_FREE, 16'h8000, 16'd2021, 1'b0);
		add_row(ACT_FREE, 16'h7FFF, 16'd2016, 1'b0);
		add_row(ACT_FREE, 16'h0000, 16'd1952, 1'b0);
		add_row(ACT_ALLOC, 16'd2047, 16'h0000, 1'b0);
		add_row(ACT_CLEAR, 16'h1234, 16'h4321, 1'b1, ST_OK, 0, 0);
		add_row(ACT_ALLOC, 16'd64, 16'h0000, 1'b0);
		add_row(ACT_FREE, 16'h0000, 16'd2016, 1'b0);
		add_row(ACT_QUERY, 16'h0000, 16'h0000, 1'b0);
		add_row(ACT_ALLOC, 16'd1024, 16'h0000, 1'b0);
		add_row(ACT_FREE, 16'h0000, 16'd0, 1'b0);
		add_row(ACT_FREE, 16'h0000, 16'd2047, 1'b0);
		add_row(ACT_QUERY, 16'hFFFF, 16'hFFFF, 1'b0);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			issue(dir_rows[i].act, dir_rows[i].size, dir_rows[i].off,
				dir_rows[i].typed, dir_rows[i].res);

		for (int phase = 0; phase < 3; phase++) begin
			drain_hold();
			tx_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 78 : 0;
			rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 34 : 0;
			for (int n = 0; n < RANDOM_ITEMS / 3; n++)
				random_item();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
